/* src/rdad_pkg.sv */
// Shared definitions for the port-mapped record disk adapter.
// Port numbers, status bits, command codes and stream widths.
// No dependencies; used by the top level and its checker.
package rdad_pkg;

  // Stream payload widths, padded to whole bytes.
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 8;

  // Claimed I/O ports.
  localparam logic [7:0] PORT_COMMAND  = 8'h10;
  localparam logic [7:0] PORT_DRIVE    = 8'h11;
  localparam logic [7:0] PORT_REC_LO   = 8'h12;
  localparam logic [7:0] PORT_REC_HI   = 8'h13;
  localparam logic [7:0] PORT_DATA     = 8'h14;
  localparam logic [7:0] PORT_ACTIVATE = 8'h15;

  // Status bits.
  localparam logic [7:0] ST_READY      = 8'h01;
  localparam logic [7:0] ST_DATA_READY = 8'h02;
  localparam logic [7:0] ST_DATA_ROOM  = 8'h04;
  localparam logic [7:0] ST_ERROR      = 8'h80;

  // Commands written to the command port.
  localparam logic [7:0] CMD_READ      = 8'h01;
  localparam logic [7:0] CMD_OPEN_LO   = 8'h02;
  localparam logic [7:0] CMD_OPEN_HI   = 8'h04;
  localparam logic [7:0] CMD_SET_READY = 8'h05;

  // Access kinds carried in the action field.
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // The record-written map holds one bit per record in words of this size.
  localparam int MAP_SEL_W = 5;
  localparam int MAP_BITS  = 32;

endpackage

/* src/port_mapped_record_disk_adapter.sv */
// Port-mapped record disk adapter: top level with the access sequencer.
// Depends on rdad_pkg and on rdad_ram for the buffer, store and record map.
// Register and status transactions return their result through the result register; a
// data-port read passes through the buffer's read register, then the result register.
// Command 1 keeps the block busy through S_BASE1, S_BASE2 and the store-to-buffer copy,
// commands 2 to 4 through S_BASE1 and S_BASE2, and a record-completing data write
// through the buffer-to-store copy, each byte via one memory port. Reset is synchronous;
// afterwards a clearing pass empties the record map; no transaction is taken meanwhile.
module port_mapped_record_disk_adapter #(
  parameter int DRIVE_COUNT       = 4,
  parameter int RECORDS_PER_DRIVE = 2560,
  parameter int RECORD_SIZE       = 128
) (
  input  logic                         clk,
  input  logic                         rst,
  // s_tdata fields, lowest bit up: port[7:0], write_data[15:8].
  input  logic [rdad_pkg::S_DATA_W-1:0] s_tdata,
  // s_tuser fields, lowest bit up: action[0] (0 port read, 1 port write).
  input  logic                         s_tuser,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // m_tdata fields, lowest bit up: read_data[7:0].
  output logic [rdad_pkg::M_DATA_W-1:0] m_tdata,
  // m_tuser fields, lowest bit up: port_claimed[0].
  output logic                         m_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready
);

  // Sizes of the store and of the record-written map. The map keeps one bit per
  // record so that records never written read back as zeros, as after a blank
  // preload, without clearing the whole store.
  localparam int TOTAL_RECORDS = DRIVE_COUNT * RECORDS_PER_DRIVE;
  localparam int STORE_DEPTH   = TOTAL_RECORDS * RECORD_SIZE;
  localparam int AW            = $clog2(STORE_DEPTH);
  localparam int MAP_WORDS     = (TOTAL_RECORDS + rdad_pkg::MAP_BITS - 1) / rdad_pkg::MAP_BITS;
  localparam int WIW           = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IXW           = WIW + rdad_pkg::MAP_SEL_W;
  localparam int BW            = $clog2(RECORD_SIZE);
  localparam int CW            = $clog2(RECORD_SIZE + 1);
  localparam int LDW           = (DRIVE_COUNT > 1) ? $clog2(DRIVE_COUNT) : 1;

  typedef enum logic [2:0] {
    S_CLEAR,   // clearing pass over the record-written map
    S_IDLE,    // waiting for a transaction
    S_BUFRD,   // buffer read data is on its way to the result register
    S_BASE1,   // record index from the latched drive and record
    S_BASE2,   // byte address of the record in the store
    S_LOAD,    // copy store to buffer
    S_STORE    // copy buffer to store
  } state_t;

  state_t state;

  // Programmer-visible registers.
  logic [7:0]     status_byte;
  logic [7:0]     drive_select;
  logic [15:0]    record_number;
  logic [CW-1:0]  byte_pointer;
  logic [LDW-1:0] latched_drive;
  logic [15:0]    latched_record;

  // Sequencer registers.
  logic [IXW-1:0] rec_idx;
  logic [AW-1:0]  base_addr;
  logic [CW-1:0]  cnt;
  logic [WIW-1:0] clr_idx;
  logic           do_load;

  // Result register.
  logic [7:0]     read_data;
  logic           port_claimed;

  // Memory ports.
  logic                          buf_we, buf_re;
  logic [BW-1:0]                 buf_waddr, buf_raddr;
  logic [7:0]                    buf_wdata, buf_rdata;
  logic                          st_we, st_re;
  logic [AW-1:0]                 st_waddr, st_raddr;
  logic [7:0]                    st_rdata;
  logic                          map_we;
  logic [WIW-1:0]                map_waddr, map_raddr;
  logic [rdad_pkg::MAP_BITS-1:0] map_wdata, map_rdata;

  // Decoded input transaction.
  logic       accept;
  logic       action;
  logic [7:0] port;
  logic [7:0] write_data;
  logic       claimed;
  logic       data_rd_ok;
  logic       data_wr_ok;
  logic       sel_ok;
  logic       ptr_last;
  logic       rec_loaded;

  assign action     = s_tuser;
  assign port       = s_tdata[7:0];
  assign write_data = s_tdata[15:8];

  // A new transaction is taken only when the sequencer is idle and the result
  // register is empty or being emptied in this cycle.
  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign claimed    = (port >= rdad_pkg::PORT_COMMAND) && (port <= rdad_pkg::PORT_ACTIVATE);
  assign data_rd_ok = ((status_byte & rdad_pkg::ST_DATA_READY) != 8'h00)
                      && (byte_pointer < CW'(RECORD_SIZE));
  assign data_wr_ok = ((status_byte & rdad_pkg::ST_DATA_ROOM) != 8'h00)
                      && (byte_pointer < CW'(RECORD_SIZE));
  assign sel_ok     = ({1'b0, drive_select} < 9'(DRIVE_COUNT))
                      && ({1'b0, record_number} < 17'(RECORDS_PER_DRIVE));
  assign ptr_last   = (byte_pointer == CW'(RECORD_SIZE - 1));
  assign rec_loaded = map_rdata[rec_idx[rdad_pkg::MAP_SEL_W-1:0]];

  assign m_tdata = read_data;
  assign m_tuser = port_claimed;

  // Record buffer: written by data-port writes and by the store-to-buffer copy,
  // read by data-port reads and by the buffer-to-store copy.
  always_comb begin
    buf_we    = 1'b0;
    buf_waddr = byte_pointer[BW-1:0];
    buf_wdata = write_data;
    if (state == S_LOAD && cnt != '0) begin
      buf_we    = 1'b1;
      buf_waddr = BW'(cnt - CW'(1));
      buf_wdata = rec_loaded ? st_rdata : 8'h00;
    end else if (accept && action == rdad_pkg::ACT_WRITE
                 && port == rdad_pkg::PORT_DATA && data_wr_ok) begin
      buf_we = 1'b1;
    end
    if (state == S_STORE) begin
      buf_re    = (cnt < CW'(RECORD_SIZE));
      buf_raddr = cnt[BW-1:0];
    end else begin
      buf_re    = (byte_pointer < CW'(RECORD_SIZE));
      buf_raddr = byte_pointer[BW-1:0];
    end
  end

  // Disk store: one byte per cycle in either direction at the latched record.
  assign st_re    = (state == S_LOAD) && (cnt < CW'(RECORD_SIZE));
  assign st_raddr = base_addr + AW'(cnt);
  assign st_we    = (state == S_STORE) && (cnt != '0);
  assign st_waddr = base_addr + AW'(cnt - CW'(1));

  // Record-written map: the word of the latched record is read continuously, so
  // its data is current by the time a copy starts. A store sets the record's bit
  // with a read-modify-write on the first copy cycle.
  assign map_raddr = rec_idx[IXW-1:rdad_pkg::MAP_SEL_W];
  always_comb begin
    map_we    = 1'b0;
    map_waddr = clr_idx;
    map_wdata = '0;
    if (state == S_CLEAR) begin
      map_we = 1'b1;
    end else if (state == S_STORE && cnt == '0) begin
      map_we    = 1'b1;
      map_waddr = map_raddr;
      map_wdata = map_rdata
                  | (rdad_pkg::MAP_BITS'(1) << rec_idx[rdad_pkg::MAP_SEL_W-1:0]);
    end
  end

  rdad_ram #(.WIDTH(8), .DEPTH(RECORD_SIZE), .AW(BW)) u_buffer (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .re    (buf_re),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  rdad_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (buf_rdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  rdad_ram #(.WIDTH(rdad_pkg::MAP_BITS), .DEPTH(MAP_WORDS), .AW(WIW)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (1'b1),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // Sequencer, visible registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      status_byte    <= rdad_pkg::ST_READY;
      drive_select   <= '0;
      record_number  <= '0;
      byte_pointer   <= '0;
      latched_drive  <= '0;
      latched_record <= '0;
      rec_idx        <= '0;
      base_addr      <= '0;
      cnt            <= '0;
      clr_idx        <= '0;
      do_load        <= 1'b0;
      m_tvalid       <= 1'b0;
      read_data      <= '0;
      port_claimed   <= 1'b0;
    end else begin
      // A result taken by the sink empties the register unless a new one replaces it.
      if (m_tvalid && m_tready && !accept) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + WIW'(1);
          if (clr_idx == WIW'(MAP_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            // Every transaction but a valid data-port read answers right away.
            m_tvalid     <= !(action == rdad_pkg::ACT_READ
                              && port == rdad_pkg::PORT_DATA && data_rd_ok);
            port_claimed <= claimed;
            if (action == rdad_pkg::ACT_READ) begin
              case (port)
                rdad_pkg::PORT_COMMAND: read_data <= status_byte;
                rdad_pkg::PORT_DRIVE:   read_data <= drive_select;
                rdad_pkg::PORT_REC_LO:  read_data <= record_number[7:0];
                rdad_pkg::PORT_REC_HI:  read_data <= record_number[15:8];
                rdad_pkg::PORT_DATA: begin
                  read_data <= 8'h00;
                  if (data_rd_ok) begin
                    state <= S_BUFRD;
                  end
                end
                default: read_data <= 8'h00;
              endcase
            end else begin
              read_data <= 8'h00;
              case (port)
                rdad_pkg::PORT_COMMAND: begin
                  byte_pointer <= '0;
                  if (write_data inside {[rdad_pkg::CMD_READ : rdad_pkg::CMD_OPEN_HI]}) begin
                    if (!sel_ok) begin
                      status_byte <= rdad_pkg::ST_ERROR;
                    end else begin
                      latched_drive  <= drive_select[LDW-1:0];
                      latched_record <= record_number;
                      do_load        <= (write_data == rdad_pkg::CMD_READ);
                      state          <= S_BASE1;
                      if (write_data == rdad_pkg::CMD_READ) begin
                        status_byte <= rdad_pkg::ST_READY | rdad_pkg::ST_DATA_READY;
                      end else begin
                        status_byte <= rdad_pkg::ST_READY | rdad_pkg::ST_DATA_ROOM;
                      end
                    end
                  end else if (write_data == rdad_pkg::CMD_SET_READY) begin
                    status_byte <= rdad_pkg::ST_READY;
                  end else begin
                    status_byte <= rdad_pkg::ST_ERROR;
                  end
                end
                rdad_pkg::PORT_DRIVE:  drive_select <= write_data;
                rdad_pkg::PORT_REC_LO: record_number[7:0] <= write_data;
                rdad_pkg::PORT_REC_HI: record_number[15:8] <= write_data;
                rdad_pkg::PORT_DATA: begin
                  if (data_wr_ok) begin
                    byte_pointer <= byte_pointer + CW'(1);
                    // The byte that fills the buffer starts the copy to the store.
                    if (ptr_last) begin
                      status_byte <= rdad_pkg::ST_READY;
                      cnt         <= '0;
                      state       <= S_STORE;
                    end
                  end
                end
                default: ;
              endcase
            end
          end
        end

        S_BUFRD: begin
          m_tvalid     <= 1'b1;
          read_data    <= buf_rdata;
          port_claimed <= 1'b1;
          byte_pointer <= byte_pointer + CW'(1);
          if (ptr_last) begin
            status_byte <= rdad_pkg::ST_READY;
          end
          state <= S_IDLE;
        end

        S_BASE1: begin
          rec_idx <= IXW'(latched_drive * IXW'(RECORDS_PER_DRIVE)) + IXW'(latched_record);
          state   <= S_BASE2;
        end

        S_BASE2: begin
          base_addr <= AW'(rec_idx * AW'(RECORD_SIZE));
          cnt       <= '0;
          state     <= do_load ? S_LOAD : S_IDLE;
        end

        S_LOAD: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(RECORD_SIZE)) begin
            state <= S_IDLE;
          end
        end

        S_STORE: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(RECORD_SIZE)) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/rdad_ram.sv */
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Read data is registered from the read address while re is high; no dependencies.
module rdad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/rdad_check.sv */
// Port-level checker for the port-mapped record disk adapter, bound to the top level.
// Depends on rdad_pkg for port numbers and stream widths.
module rdad_check (
  input logic                          clk,
  input logic                          rst,
  input logic [rdad_pkg::S_DATA_W-1:0] s_tdata,
  input logic                          s_tuser,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [rdad_pkg::M_DATA_W-1:0] m_tdata,
  input logic                          m_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready
);

  logic in_claimed;

  assign in_claimed = (s_tdata[7:0] >= rdad_pkg::PORT_COMMAND)
                      && (s_tdata[7:0] <= rdad_pkg::PORT_ACTIVATE);

  // A result waiting for the sink holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Right after reset the block takes nothing and holds no result while the record map is cleared.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("transaction possible right after reset");

  // A port write answers in the next cycle with zero data and the claim flag.
  a_write_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == rdad_pkg::ACT_WRITE
    |=> m_tvalid && m_tdata == 8'h00 && m_tuser == $past(in_claimed))
    else $error("wrong result for a port write");

  // A read of any port but the data port answers in the next cycle.
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == rdad_pkg::ACT_READ
    && s_tdata[7:0] != rdad_pkg::PORT_DATA
    |=> m_tvalid && m_tuser == $past(in_claimed))
    else $error("wrong result for a register read");

endmodule

bind port_mapped_record_disk_adapter rdad_check u_rdad_check (.*);
